// ----- hdl/afrx16_pkg.sv -----
// Shared types and constants for the 16-bit address receive frame parser.
`timescale 1ns / 1ps
`default_nettype none

package afrx16_pkg;

    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [7:0]  RX16_TYPE  = 8'h81;
    localparam logic [15:0] HDR_BYTES  = 16'd5;
    localparam logic [7:0]  CSUM_BASE  = 8'hFF;

    // Payload lengths and counters never exceed 255 bytes.
    localparam int LEN_W = 8;

    typedef enum logic [3:0] {
        ST_HUNT   = 4'd0,
        ST_LEN_HI = 4'd1,
        ST_LEN_LO = 4'd2,
        ST_TYPE   = 4'd3,
        ST_SRC_HI = 4'd4,
        ST_SRC_LO = 4'd5,
        ST_RSSI   = 4'd6,
        ST_OPT    = 4'd7,
        ST_DATA   = 4'd8,
        ST_CSUM   = 4'd9
    } t_parse_state;

    // Handed from the parser to the read-out sequencer on a verified checksum.
    typedef struct packed {
        logic             go;
        logic [15:0]      src;
        logic [LEN_W-1:0] len;
    } t_frame_info;

    // Read-out status seen by the parser.
    typedef struct packed {
        logic busy;     // reads still to issue or in flight
        logic holding;  // output register holds a result
    } t_rd_status;

endpackage

`default_nettype wire

// ----- hdl/afrx16_pay_mem.sv -----
// Payload store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module afrx16_pay_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hdl/afrx16_parser.sv -----
// Byte-level frame parser: header decode, running sum, payload writes, checksum check.
`timescale 1ns / 1ps
`default_nettype none

module afrx16_parser
    import afrx16_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int AW          = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    input  wire t_rd_status    i_status,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [7:0]         o_wr_data,
    output t_frame_info        o_frame
);

    t_parse_state     r_state, n_state;
    logic [15:0]      r_len;
    logic [15:0]      r_sender;
    logic [7:0]       r_sum;
    logic [LEN_W-1:0] r_cnt;

    logic             accept;
    logic             len_ok;
    logic [LEN_W-1:0] cnt_inc;
    logic             csum_ok;

    assign accept  = i_valid && o_ready;
    assign len_ok  = (r_len >= HDR_BYTES) &&
                     ({1'b0, r_len} <= 17'(MAX_PAYLOAD + 5));
    assign cnt_inc = r_cnt + LEN_W'(1);
    assign csum_ok = (i_byte == (CSUM_BASE - r_sum));

    // Next state.
    always_comb begin
        n_state = r_state;
        if (accept) begin
            unique case (r_state)
                ST_HUNT:   n_state = (i_byte == START_BYTE) ? ST_LEN_HI : ST_HUNT;
                ST_LEN_HI: n_state = ST_LEN_LO;
                ST_LEN_LO: n_state = ST_TYPE;
                ST_TYPE:   n_state = (i_byte == RX16_TYPE && len_ok) ? ST_SRC_HI : ST_HUNT;
                ST_SRC_HI: n_state = ST_SRC_LO;
                ST_SRC_LO: n_state = ST_RSSI;
                ST_RSSI:   n_state = ST_OPT;
                ST_OPT:    n_state = (r_len == 16'd0) ? ST_CSUM : ST_DATA;
                ST_DATA:   n_state = ({8'd0, cnt_inc} >= r_len) ? ST_CSUM : ST_DATA;
                ST_CSUM:   n_state = ST_HUNT;
                default:   n_state = ST_HUNT;
            endcase
        end
    end

    // Outputs.
    always_comb begin
        // A checksum byte is held back until the previous frame's last result is taken.
        o_ready   = !i_status.busy && !(r_state == ST_CSUM && i_status.holding);
        o_wr_en   = accept && (r_state == ST_DATA);
        o_wr_addr = r_cnt[AW-1:0];
        o_wr_data = i_byte;
        o_frame.go  = accept && (r_state == ST_CSUM) && csum_ok;
        o_frame.src = r_sender;
        o_frame.len = r_len[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_sender <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
        end else if (accept) begin
            unique case (r_state)
                ST_HUNT: begin
                    if (i_byte == START_BYTE) begin
                        r_sum <= '0;
                        r_cnt <= '0;
                    end
                end
                ST_LEN_HI: r_len <= {i_byte, 8'd0};
                ST_LEN_LO: r_len <= {r_len[15:8], i_byte};
                ST_TYPE: begin
                    r_sum <= r_sum + i_byte;
                    if (i_byte == RX16_TYPE && len_ok) begin
                        r_len <= r_len - HDR_BYTES;
                    end
                end
                ST_SRC_HI: begin
                    r_sender <= {i_byte, 8'd0};
                    r_sum    <= r_sum + i_byte;
                end
                ST_SRC_LO: begin
                    r_sender <= {r_sender[15:8], i_byte};
                    r_sum    <= r_sum + i_byte;
                end
                ST_RSSI: r_sum <= r_sum + i_byte;
                ST_OPT: begin
                    r_sum <= r_sum + i_byte;
                    r_cnt <= '0;
                end
                ST_DATA: begin
                    r_sum <= r_sum + i_byte;
                    r_cnt <= ({8'd0, cnt_inc} >= r_len) ? '0 : cnt_inc;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/afrx16_readout.sv -----
// Read-out sequencer: walks the payload store and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module afrx16_readout
    import afrx16_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_frame_info   i_frame,
    output t_rd_status         o_status,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  wire logic [7:0]    i_rd_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic [15:0]        o_src,
    output logic [6:0]         o_len,
    output logic               o_last
);

    logic             r_active;
    logic             r_rd_pend;
    logic             r_last_pend;
    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] r_len;
    logic [15:0]      r_src;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [15:0]      r_out_src;
    logic [6:0]       r_out_len;
    logic             r_out_last;

    logic             issue;
    logic [LEN_W-1:0] idx_inc;

    // One read in flight at a time; the output register is free when its data lands.
    assign issue   = r_active && !r_rd_pend && (!r_out_valid || i_ready);
    assign idx_inc = r_idx + LEN_W'(1);

    assign o_rd_en   = issue;
    assign o_rd_addr = r_idx[AW-1:0];

    assign o_status.busy    = r_active || r_rd_pend;
    assign o_status.holding = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_last_pend <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_rd_pend <= issue;
            if (i_frame.go && i_frame.len != '0) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (issue) begin
                r_idx       <= idx_inc;
                r_last_pend <= (idx_inc == r_len);
                if (idx_inc == r_len) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.go) begin
            r_len <= i_frame.len;
            r_src <= i_frame.src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_frame.go && i_frame.len == '0) begin
            r_out_valid <= 1'b1;
        end else if (r_rd_pend) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // An empty frame gives a single zero result marked last.
    always_ff @(posedge i_clk) begin
        if (i_frame.go && i_frame.len == '0) begin
            r_out_byte <= '0;
            r_out_src  <= i_frame.src;
            r_out_len  <= '0;
            r_out_last <= 1'b1;
        end else if (r_rd_pend) begin
            r_out_byte <= i_rd_data;
            r_out_src  <= r_src;
            r_out_len  <= r_len[6:0];
            r_out_last <= r_last_pend;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_src   = r_out_src;
    assign o_len   = r_out_len;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/api_frame_rx16_parser_unit.sv -----
// Top level of the 16-bit address receive frame parser.
// Header and payload bytes are taken one per cycle unless input is held off; the running
// sum and payload writes happen in the cycle a byte is taken. A verified frame's first
// result goes from the checksum transfer through the active flag, the store read and the
// read-pending flag to the output; an empty payload's result is loaded there directly.
// Each read waits for the one before; input is held off while the store is read out.
// Synchronous active-low reset returns the parser to hunting and empties the output;
// the payload store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module api_frame_rx16_parser_unit
    import afrx16_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [7:0] payload_byte, [23:8] source_address,
                                               // [30:24] payload_length, [31] zero
    output logic             o_m_axis_tlast
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    t_frame_info   frame;
    t_rd_status    status;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    out_byte;
    logic [15:0]   out_src;
    logic [6:0]    out_len;

    afrx16_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_status  (status),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_frame   (frame)
    );

    // Writes and reads never overlap: input is held off during read-out.
    afrx16_pay_mem #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    afrx16_readout #(
        .AW (AW)
    ) u_readout (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (frame),
        .o_status  (status),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (out_byte),
        .o_src     (out_src),
        .o_len     (out_len),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_len, out_src, out_byte};

endmodule

`default_nettype wire

// ----- hdl/afrx16_checker.sv -----
// Port-level checks for the frame parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module afrx16_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown right after reset");

    // An empty frame gives one zero byte that closes the run.
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[30:24] == 7'd0 |->
            o_m_axis_tlast && o_m_axis_tdata[7:0] == 8'd0)
        else $error("empty frame result malformed");

    // No input is taken while a run is still being read out.
    a_no_input_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input taken during read-out");

endmodule

bind api_frame_rx16_parser_unit afrx16_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ----- test/api_frame_rx16_parser_unit_tb.sv -----
// Self-checking testbench for the 16-bit address receive frame parser.
`timescale 1ns / 1ps

module api_frame_rx16_parser_unit_tb;
    import afrx16_pkg::*;

    localparam int PAYLOAD_CAP  = 64;
    localparam int RX_ITEMS     = 350;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0]  pbyte;
        logic [15:0] src;
        logic [6:0]  plen;
        logic        plast;
    } t_rx_result;

    // How a directed row is checked: frame tracker, a result typed in here, or no result.
    typedef enum logic [1:0] {
        PIN_MODEL,
        PIN_NONE,
        PIN_ONE
    } t_pin;

    typedef struct packed {
        logic [7:0] rx;
        t_pin       pin;
        t_rx_result fixed;
    } t_plan_row;

    t_plan_row plan [0:29] = '{
        // Verified empty frame from the all-ones address.
        '{8'h7E, PIN_MODEL, '0}, '{8'h00, PIN_MODEL, '0}, '{8'h05, PIN_MODEL, '0},
        '{8'h81, PIN_MODEL, '0}, '{8'hFF, PIN_MODEL, '0}, '{8'hFF, PIN_MODEL, '0},
        '{8'h00, PIN_MODEL, '0}, '{8'h00, PIN_MODEL, '0},
        '{8'h80, PIN_ONE, '{8'h00, 16'hFFFF, 7'd0, 1'b1}},
        // Empty frame with a start byte as signal strength and a bad checksum.
        '{8'h7E, PIN_MODEL, '0}, '{8'h00, PIN_MODEL, '0}, '{8'h05, PIN_MODEL, '0},
        '{8'h81, PIN_MODEL, '0}, '{8'h00, PIN_MODEL, '0}, '{8'h00, PIN_MODEL, '0},
        '{8'h7E, PIN_MODEL, '0}, '{8'hFF, PIN_MODEL, '0}, '{8'h00, PIN_NONE, '0},
        // Wrong frame type.
        '{8'h7E, PIN_MODEL, '0}, '{8'h00, PIN_MODEL, '0}, '{8'h06, PIN_MODEL, '0},
        '{8'h90, PIN_NONE, '0},
        // Length too short for the header.
        '{8'h7E, PIN_MODEL, '0}, '{8'h00, PIN_MODEL, '0}, '{8'h04, PIN_MODEL, '0},
        '{8'h81, PIN_NONE, '0},
        // Largest length, far above the payload capacity.
        '{8'h7E, PIN_MODEL, '0}, '{8'hFF, PIN_MODEL, '0}, '{8'hFF, PIN_MODEL, '0},
        '{8'h81, PIN_NONE, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;           // [7:0] payload_byte, [23:8] source_address,
                                           // [30:24] payload_length, [31] zero
    logic        o_m_axis_tlast;

    // Frame tracker state.
    t_parse_state fr_state = ST_HUNT;
    logic [15:0]  fr_len = '0;
    logic [15:0]  fr_src = '0;
    logic [7:0]   fr_sum = '0;
    logic [6:0]   fr_count = '0;
    logic [7:0]   fr_store [PAYLOAD_CAP];
    t_rx_result   payload_due_q [$];

    int burst_left = 0;
    int rx_sent = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int rcv_cycle = 0;
    bit rcv_busy = 1'b0;

    api_frame_rx16_parser_unit #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advances the frame tracker by one received byte and queues the payload it releases.
    task automatic track_rx(input logic [7:0] b, input bit record);
        case (fr_state)
            ST_HUNT: begin
                if (b == START_BYTE) begin
                    fr_sum = '0;
                    fr_count = '0;
                    fr_state = ST_LEN_HI;
                end
            end
            ST_LEN_HI: begin
                fr_len = {b, 8'h00};
                fr_state = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                fr_len = {fr_len[15:8], b};
                fr_state = ST_TYPE;
            end
            ST_TYPE: begin
                fr_sum = fr_sum + b;
                if (b == RX16_TYPE && fr_len >= HDR_BYTES &&
                    fr_len - HDR_BYTES <= PAYLOAD_CAP) begin
                    fr_len = fr_len - HDR_BYTES;
                    fr_state = ST_SRC_HI;
                end else begin
                    fr_state = ST_HUNT;
                end
            end
            ST_SRC_HI: begin
                fr_src = {b, 8'h00};
                fr_sum = fr_sum + b;
                fr_state = ST_SRC_LO;
            end
            ST_SRC_LO: begin
                fr_src = {fr_src[15:8], b};
                fr_sum = fr_sum + b;
                fr_state = ST_RSSI;
            end
            ST_RSSI: begin
                fr_sum = fr_sum + b;
                fr_state = ST_OPT;
            end
            ST_OPT: begin
                fr_sum = fr_sum + b;
                fr_count = '0;
                fr_state = (fr_len == 0) ? ST_CSUM : ST_DATA;
            end
            ST_DATA: begin
                fr_store[fr_count] = b;
                fr_count = fr_count + 1'b1;
                fr_sum = fr_sum + b;
                if (fr_count >= fr_len) begin
                    fr_count = '0;
                    fr_state = ST_CSUM;
                end
            end
            ST_CSUM: begin
                if (b == CSUM_BASE - fr_sum && record) begin
                    if (fr_len == 0) begin
                        payload_due_q.push_back('{8'h00, fr_src, 7'd0, 1'b1});
                    end else begin
                        for (int i = 0; i < fr_len; i++)
                            payload_due_q.push_back('{fr_store[i], fr_src, fr_len[6:0],
                                                      (i + 1 == fr_len)});
                    end
                end
                fr_state = ST_HUNT;
            end
            default: fr_state = ST_HUNT;
        endcase
    endtask

    // Offers one byte in bursts separated by random gaps; valid stays high within a burst.
    task automatic send_rx(input logic [7:0] b, input t_pin pin, input t_rx_result fixed,
                           input bit counted);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        track_rx(b, pin == PIN_MODEL);
        if (pin == PIN_ONE) payload_due_q.push_back(fixed);
        if (counted) rx_sent++;
    endtask

    // One random frame: mostly well-formed with random content, the rest broken or noise.
    task automatic send_frame();
        logic [7:0]  fb [$];
        logic [7:0]  v;
        logic [7:0]  sum;
        logic [15:0] flen;
        int kind;
        int plen;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 3)) begin
                v = 8'($urandom_range(0, 255));
                if (v == START_BYTE) v = 8'h7F;
                send_rx(v, PIN_MODEL, '0, 1'b0);
            end
            return;
        end
        fb.push_back(START_BYTE);
        if (kind < 24) begin
            v = RX16_TYPE;
            if (kind < 14) begin
                flen = 16'($urandom_range(5, 69));
                v = 8'($urandom_range(0, 255));
                if (v == RX16_TYPE) v = 8'h80;
            end else if (kind < 19) begin
                flen = 16'($urandom_range(0, 4));
            end else begin
                flen = 16'($urandom_range(70, 65535));
            end
            fb.push_back(flen[15:8]);
            fb.push_back(flen[7:0]);
            fb.push_back(v);
        end else begin
            pick = $urandom_range(0, 99);
            plen = (pick < 6) ? PAYLOAD_CAP :
                   (pick < 20) ? $urandom_range(9, PAYLOAD_CAP - 1) : $urandom_range(0, 8);
            flen = 16'(plen) + HDR_BYTES;
            fb.push_back(flen[15:8]);
            fb.push_back(flen[7:0]);
            fb.push_back(RX16_TYPE);
            sum = RX16_TYPE;
            // Address, signal strength, option, then the payload.
            repeat (4 + plen) begin
                v = 8'($urandom_range(0, 255));
                fb.push_back(v);
                sum = sum + v;
            end
            v = CSUM_BASE - sum;
            if (kind < 32) v = v ^ 8'($urandom_range(1, 255));
            fb.push_back(v);
            // A cut-off frame makes the parser swallow what follows as frame bytes.
            if (kind >= 32 && kind < 36)
                repeat ($urandom_range(1, fb.size() - 1)) void'(fb.pop_back());
        end
        foreach (fb[k]) send_rx(fb[k], PIN_MODEL, '0, 1'b1);
    endtask

    // Receiver: stall-free stretches alternate with stretches of short random stalls.
    always @(posedge i_clk) begin
        if (rcv_cycle % 300 == 0) rcv_busy = ($urandom_range(0, 3) != 0);
        rcv_cycle++;
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (rcv_busy && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rx_result got;
        t_rx_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[7:0], o_m_axis_tdata[23:8], o_m_axis_tdata[30:24],
                    o_m_axis_tlast};
            if (payload_due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: byte %02h src %04h len %0d last %0b",
                             got.pbyte, got.src, got.plen, got.plast);
            end else begin
                want = payload_due_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result mismatch: expected byte %02h src %04h len %0d last %0b,",
                                 want.pbyte, want.src, want.plen, want.plast,
                                 " got byte %02h src %04h len %0d last %0b",
                                 got.pbyte, got.src, got.plen, got.plast);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (plan[k]) send_rx(plan[k].rx, plan[k].pin, plan[k].fixed, 1'b1);
        while (rx_sent < RX_ITEMS) send_frame();
        i_s_axis_tvalid <= 1'b0;
        while (payload_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && payload_due_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
